@@ rtl/core/isc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer subset CPU core package
// Shared payload types, encodings and sizing constants for the core.
// ----------------------------------------------------------------------------
package isc_pkg;

	// Data memory size in words and its index width.
	localparam int DMEM_WORDS = 128;
	localparam int DMEM_AW    = $clog2(DMEM_WORDS);

	// Reset value of the data base register.
	localparam logic [31:0] DATA_BASE_RST = 32'd268500992;

	// Request types.
	localparam logic [1:0] REQ_EXEC     = 2'd0;
	localparam logic [1:0] REQ_PRE_REG  = 2'd1;
	localparam logic [1:0] REQ_PRE_DATA = 2'd2;
	localparam logic [1:0] REQ_RD_DATA  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ADDR_ERR = 2'd1;
	localparam logic [1:0] ST_BAD_OP   = 2'd2;

	// Opcodes.
	localparam logic [5:0] OP_RTYPE = 6'b000000;
	localparam logic [5:0] OP_BEQ   = 6'b000100;
	localparam logic [5:0] OP_BNE   = 6'b000101;
	localparam logic [5:0] OP_LW    = 6'b100011;
	localparam logic [5:0] OP_SW    = 6'b101011;
	localparam logic [5:0] OP_ADDI  = 6'b001000;
	localparam logic [5:0] OP_J     = 6'b000010;
	localparam logic [5:0] OP_JAL   = 6'b000011;

	// Function codes under the R-type opcode.
	localparam logic [5:0] FN_SLL = 6'b000000;
	localparam logic [5:0] FN_JR  = 6'b001000;
	localparam logic [5:0] FN_ADD = 6'b100000;
	localparam logic [5:0] FN_SUB = 6'b100010;
	localparam logic [5:0] FN_SLT = 6'b101010;

	// Link register written by jal.
	localparam logic [4:0] REG_LINK = 5'd31;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        instr_word;
		logic [31:0]        instr_addr;
		logic [6:0]         target_index;
		logic signed [31:0] load_value;
	} isc_req_t;

	typedef struct packed {
		logic [31:0]        next_addr;
		logic               reg_write_en;
		logic [4:0]         dest_reg;
		logic signed [31:0] write_value;
		logic               mem_write_en;
		logic [31:0]        data_address;
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} isc_rsp_t;

	// Decoded effects of one item, handed from the execute unit to the pipeline.
	typedef struct packed {
		logic [31:0]        next_addr;
		logic               reg_we;
		logic [4:0]         dest;
		logic [31:0]        wval;
		logic               mem_we;
		logic               mem_re;
		logic [DMEM_AW-1:0] mem_idx;
		logic [31:0]        mem_wdata;
		logic [31:0]        daddr;
		logic [1:0]         status;
	} isc_exec_t;

endpackage
`default_nettype wire

@@ rtl/core/isc_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer subset execute unit
// Decodes one item and computes its register, memory and next-address effects.
// ----------------------------------------------------------------------------
module isc_exec
	import isc_pkg::*;
(
	input  wire isc_req_t    req,
	input  wire logic [31:0] opa,
	input  wire logic [31:0] opb,
	input  wire logic [31:0] data_base,
	output isc_exec_t        ex
);

	logic [5:0]  op;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [31:0] imm;
	logic [31:0] seq;
	logic [31:0] jt;
	logic [31:0] ea;
	logic [31:0] ea_off;
	logic        ea_in;
	logic [31:0] tix_ext;
	logic        tix_in;
	logic [31:0] alu;
	logic        alu_we;

	always_comb begin
		op      = req.instr_word[31:26];
		rt      = req.instr_word[20:16];
		rd      = req.instr_word[15:11];
		sh      = req.instr_word[10:6];
		fn      = req.instr_word[5:0];
		imm     = {{16{req.instr_word[15]}}, req.instr_word[15:0]};
		seq     = req.instr_addr + 32'd4;
		jt      = {seq[31:28], req.instr_word[25:0], 2'b00};
		ea      = opa + imm;
		ea_off  = ea - data_base;
		ea_in   = ea_off < 32'(DMEM_WORDS * 4);
		tix_ext = {25'd0, req.target_index};
		tix_in  = tix_ext < 32'(DMEM_WORDS);

		alu    = '0;
		alu_we = 1'b1;
		unique case (fn)
			FN_ADD:  alu = opa + opb;
			FN_SUB:  alu = opa - opb;
			FN_SLT:  alu = {31'd0, $signed(opa) < $signed(opb)};
			FN_SLL:  alu = opb << sh;
			default: alu_we = 1'b0;
		endcase

		ex           = '0;
		ex.mem_wdata = opb;

		unique case (req.req_type)
			REQ_PRE_REG: begin
				if (req.target_index[6:5] == 2'b00 && req.target_index[4:0] != 5'd0) begin
					ex.reg_we = 1'b1;
					ex.dest   = req.target_index[4:0];
					ex.wval   = req.load_value;
				end
			end
			REQ_PRE_DATA, REQ_RD_DATA: begin
				ex.daddr   = data_base + {tix_ext[29:0], 2'b00};
				ex.mem_idx = tix_ext[DMEM_AW-1:0];
				if (!tix_in) begin
					ex.status = ST_ADDR_ERR;
				end else if (req.req_type == REQ_PRE_DATA) begin
					ex.mem_we    = 1'b1;
					ex.mem_wdata = req.load_value;
				end else begin
					ex.mem_re = 1'b1;
				end
			end
			default: begin
				ex.next_addr = seq;
				unique case (op)
					OP_RTYPE: begin
						if (alu_we && rd != 5'd0) begin
							ex.reg_we = 1'b1;
							ex.dest   = rd;
							ex.wval   = alu;
						end
						if (fn == FN_JR) begin
							ex.next_addr = opa;
						end
					end
					OP_LW: begin
						ex.daddr   = ea;
						ex.mem_idx = ea_off[DMEM_AW+1:2];
						if (ea_in) begin
							ex.mem_re = 1'b1;
							if (rt != 5'd0) begin
								ex.reg_we = 1'b1;
								ex.dest   = rt;
							end
						end else begin
							ex.status = ST_ADDR_ERR;
						end
					end
					OP_SW: begin
						ex.daddr   = ea;
						ex.mem_idx = ea_off[DMEM_AW+1:2];
						if (ea_in) begin
							ex.mem_we = 1'b1;
						end else begin
							ex.status = ST_ADDR_ERR;
						end
					end
					OP_ADDI: begin
						if (rt != 5'd0) begin
							ex.reg_we = 1'b1;
							ex.dest   = rt;
							ex.wval   = ea;
						end
					end
					OP_BEQ: begin
						if (opa == opb) begin
							ex.next_addr = seq + {imm[29:0], 2'b00};
						end
					end
					OP_BNE: begin
						if (opa != opb) begin
							ex.next_addr = seq + {imm[29:0], 2'b00};
						end
					end
					OP_J: begin
						ex.next_addr = jt;
					end
					OP_JAL: begin
						ex.reg_we    = 1'b1;
						ex.dest      = REG_LINK;
						ex.wval      = seq;
						ex.next_addr = jt;
					end
					default: begin
						ex.status = ST_BAD_OP;
					end
				endcase
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/integer_subset_cpu_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer subset CPU core
// Executes one instruction, register preload, data preload or data read per
// beat against a 32-entry register file and a word data memory.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Beat contents
//   in        input      in_valid / in_ready        isc_req_t (one request)
//   out       output     out_valid / out_ready      isc_rsp_t (one response)
//   cfg       input      cfg_wr_en (no wait)        data_base register value
//
// Each request passes the request stage, holding the request and its register
// operands, then the response register. One request can enter in every cycle
// while the response register is free. The data memory read port sets the
// depth: load data is registered as the request moves into the response
// stage, and is bypassed back to a dependent request directly. Reset clears
// all control state and the valid bits of the register file and data memory,
// so every entry reads as zero afterward, and sets the data base register to
// DATA_BASE_RST. When out_ready is low the response holds; the request stage
// keeps accepting while empty, and stalls only once it also holds a beat.
//
module integer_subset_cpu_core
	import isc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire isc_req_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output isc_rsp_t         out_data,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	// Configuration.
	logic [31:0] data_base_q;

	// Register file: storage without reset plus one valid bit per entry, so a
	// register never written reads as zero. Register zero is never written.
	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;

	// Data memory with one valid bit per word for the clear-at-reset behavior.
	logic [31:0]           dm_mem [DMEM_WORDS];
	logic [DMEM_WORDS-1:0] dm_vld_q;

	// Request stage.
	logic        s1_vld_q;
	isc_req_t    req_s1;
	logic [31:0] opa_s1;
	logic [31:0] opb_s1;

	// Response stage.
	logic               s2_vld_q;
	logic [31:0]        next_s2;
	logic               we_s2;
	logic [4:0]         dest_s2;
	logic [31:0]        wval_s2;
	logic               mwe_s2;
	logic               re_s2;
	logic [31:0]        daddr_s2;
	logic [1:0]         stat_s2;
	logic [31:0]        mrd_s2;
	logic               mrd_vld_s2;
	logic               wb_pend_q;

	// Handshake and datapath nets.
	logic        s2_free;
	logic        s1_move;
	logic        in_acc;
	logic [4:0]  rs_in;
	logic [4:0]  rt_in;
	logic [4:0]  rs_s1;
	logic [4:0]  rt_s1;
	logic [31:0] mem_val;
	logic        ld_s2;
	logic [31:0] wb_val;
	logic [31:0] opa;
	logic [31:0] opb;
	isc_exec_t   ex;

	// The response register frees up when it is empty or being taken, and the
	// request stage refills as soon as its beat moves on.
	assign s2_free  = !s2_vld_q || out_ready;
	assign s1_move  = s1_vld_q && s2_free;
	assign in_ready = !s1_vld_q || s2_free;
	assign in_acc   = in_valid && in_ready;

	assign rs_in = in_data.instr_word[25:21];
	assign rt_in = in_data.instr_word[20:16];
	assign rs_s1 = req_s1.instr_word[25:21];
	assign rt_s1 = req_s1.instr_word[20:16];

	// Write-back value of the response stage. A load writes the word it read,
	// every other writer the value computed in the request stage.
	assign mem_val = mrd_vld_s2 ? mrd_s2 : 32'd0;
	assign ld_s2   = re_s2 && we_s2;
	assign wb_val  = ld_s2 ? mem_val : wval_s2;

	// The response stage writes the register file in the cycle after it fills.
	// Until then a younger request in the first stage sees that value through
	// this bypass, which covers load data as well.
	assign opa = (wb_pend_q && dest_s2 == rs_s1) ? wb_val : opa_s1;
	assign opb = (wb_pend_q && dest_s2 == rt_s1) ? wb_val : opb_s1;

	isc_exec u_exec (
		.req       (req_s1),
		.opa       (opa),
		.opb       (opb),
		.data_base (data_base_q),
		.ex        (ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q <= DATA_BASE_RST;
		end else if (cfg_wr_en) begin
			data_base_q <= cfg_wr_data;
		end
	end

	// Stage valid bits and the write-back flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			s2_vld_q  <= 1'b0;
			wb_pend_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_move) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_move) begin
				s2_vld_q <= 1'b1;
			end else if (out_ready) begin
				s2_vld_q <= 1'b0;
			end
			wb_pend_q <= s1_move && ex.reg_we;
		end
	end

	// Request stage payload. Operands are read at acceptance, taking a
	// write-back of the same edge into account, and are refreshed while the
	// request waits so they never go stale.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= in_data;
			if (wb_pend_q && dest_s2 == rs_in) begin
				opa_s1 <= wb_val;
			end else begin
				opa_s1 <= rf_vld_q[rs_in] ? rf_mem[rs_in] : 32'd0;
			end
			if (wb_pend_q && dest_s2 == rt_in) begin
				opb_s1 <= wb_val;
			end else begin
				opb_s1 <= rf_vld_q[rt_in] ? rf_mem[rt_in] : 32'd0;
			end
		end else begin
			opa_s1 <= opa;
			opb_s1 <= opb;
		end
	end

	// Response stage payload.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			next_s2  <= ex.next_addr;
			we_s2    <= ex.reg_we;
			dest_s2  <= ex.dest;
			wval_s2  <= ex.wval;
			mwe_s2   <= ex.mem_we;
			re_s2    <= ex.mem_re;
			daddr_s2 <= ex.daddr;
			stat_s2  <= ex.status;
		end
	end

	// Register file write port.
	always_ff @(posedge clk) begin
		if (wb_pend_q) begin
			rf_mem[dest_s2] <= wb_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wb_pend_q) begin
			rf_vld_q[dest_s2] <= 1'b1;
		end
	end

	// Data memory: at most one access per request, as the request leaves the first
	// stage, so a later request always sees an earlier store.
	always_ff @(posedge clk) begin
		if (s1_move && ex.mem_we) begin
			dm_mem[ex.mem_idx] <= ex.mem_wdata;
		end
		if (s1_move && ex.mem_re) begin
			mrd_s2 <= dm_mem[ex.mem_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm_vld_q   <= '0;
			mrd_vld_s2 <= 1'b0;
		end else if (s1_move) begin
			if (ex.mem_we) begin
				dm_vld_q[ex.mem_idx] <= 1'b1;
			end
			if (ex.mem_re) begin
				mrd_vld_s2 <= dm_vld_q[ex.mem_idx];
			end
		end
	end

	assign out_valid = s2_vld_q;

	always_comb begin
		out_data              = '0;
		out_data.next_addr    = next_s2;
		out_data.reg_write_en = we_s2;
		out_data.dest_reg     = dest_s2;
		out_data.write_value  = $signed(wb_val);
		out_data.mem_write_en = mwe_s2;
		out_data.data_address = daddr_s2;
		out_data.read_value   = re_s2 ? $signed(mem_val) : 32'sd0;
		out_data.status       = stat_s2;
	end

endmodule
`default_nettype wire

@@ rtl/core/isc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer subset CPU core checker
// Port-level properties of the core's responses, bound to the top level.
// ----------------------------------------------------------------------------
module isc_checker
	import isc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire isc_rsp_t    out_data
);

	// A stalled response beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// Register zero is never reported as written.
	a_no_reg0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reg_write_en |-> out_data.dest_reg != 5'd0)
		else $error("write to register zero reported");

	// With no register write, the write fields stay zero.
	a_no_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reg_write_en |->
			out_data.dest_reg == 5'd0 && out_data.write_value == 32'sd0)
		else $error("write fields set without a register write");

	// A failed beat changes no state.
	a_err_no_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			!out_data.reg_write_en && !out_data.mem_write_en &&
			out_data.read_value == 32'sd0)
		else $error("side effect reported on a failed beat");

	// A beat is never both a store and a register write, and a store always has OK status.
	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mem_write_en |->
			!out_data.reg_write_en && out_data.status == ST_OK)
		else $error("store reported with a register write or error");

endmodule

bind integer_subset_cpu_core isc_checker u_isc_checker (.*);
`default_nettype wire

@@ tb/sv/tb_integer_subset_cpu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer subset CPU core testbench
// Drives request beats through the core and checks every response beat
// against an in-bench model of the register file, data memory and data base.
// ----------------------------------------------------------------------------
module tb_integer_subset_cpu_core;
	import isc_pkg::*;

	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_CYCLES = 4;
	localparam logic [5:0]  OP_UNUSED    = 6'b111111;
	localparam logic [5:0]  FN_UNUSED    = 6'b111111;
	localparam logic [31:0] PC_START     = 32'd4194304;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	isc_req_t    in_data     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	isc_rsp_t    out_data;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	// Architectural state as the core should see it, in acceptance order.
	logic [31:0] gpr [32];
	logic [31:0] dmem [DMEM_WORDS];
	logic [31:0] model_base;

	isc_req_t pending_reqs [$];
	isc_rsp_t expected_rsps [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count    = 0;
	int rsp_count     = 0;
	int base_count    = 1;
	int sent_by_type [4];
	int status_seen  [4];

	isc_rsp_t rsp_want;
	bit       rsp_bad;

	integer_subset_cpu_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timed out with %0d responses still owed.", expected_rsps.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Executes one request against the model state and returns its response.
	function automatic isc_rsp_t predict_beat(input isc_req_t r);
		isc_rsp_t           o;
		logic [5:0]         op, fn;
		logic [4:0]         rs, rt, rd, sh, wr_reg;
		logic [31:0]        a, b, imm, seq, ea, off, wr_val;
		logic               wr;
		logic [DMEM_AW-1:0] idx;
		o      = '0;
		wr     = 1'b0;
		wr_reg = '0;
		wr_val = '0;
		op     = r.instr_word[31:26];
		rs     = r.instr_word[25:21];
		rt     = r.instr_word[20:16];
		rd     = r.instr_word[15:11];
		sh     = r.instr_word[10:6];
		fn     = r.instr_word[5:0];
		imm    = {{16{r.instr_word[15]}}, r.instr_word[15:0]};
		a      = gpr[rs];
		b      = gpr[rt];
		seq    = r.instr_addr + 32'd4;
		ea     = a + imm;
		off    = ea - model_base;
		idx    = off[DMEM_AW+1:2];
		case (r.req_type)
			REQ_PRE_REG: begin
				if (r.target_index < 7'd32) begin
					wr     = 1'b1;
					wr_reg = r.target_index[4:0];
					wr_val = r.load_value;
				end
			end
			REQ_PRE_DATA, REQ_RD_DATA: begin
				o.data_address = model_base + {23'b0, r.target_index, 2'b00};
				if (int'(r.target_index) >= DMEM_WORDS) begin
					o.status = ST_ADDR_ERR;
				end else if (r.req_type == REQ_PRE_DATA) begin
					dmem[r.target_index] = r.load_value;
					o.mem_write_en       = 1'b1;
				end else begin
					o.read_value = dmem[r.target_index];
				end
			end
			default: begin
				o.next_addr = seq;
				case (op)
					OP_RTYPE: begin
						wr_reg = rd;
						case (fn)
							FN_ADD: begin
								wr     = 1'b1;
								wr_val = a + b;
							end
							FN_SUB: begin
								wr     = 1'b1;
								wr_val = a - b;
							end
							FN_SLT: begin
								wr     = 1'b1;
								wr_val = {31'b0, $signed(a) < $signed(b)};
							end
							FN_SLL: begin
								wr     = 1'b1;
								wr_val = b << sh;
							end
							FN_JR: o.next_addr = a;
							default: ;
						endcase
					end
					OP_LW, OP_SW: begin
						o.data_address = ea;
						if (off >= 32'(4 * DMEM_WORDS)) begin
							o.status = ST_ADDR_ERR;
						end else if (op == OP_LW) begin
							o.read_value = dmem[idx];
							wr           = 1'b1;
							wr_reg       = rt;
							wr_val       = dmem[idx];
						end else begin
							dmem[idx]      = b;
							o.mem_write_en = 1'b1;
						end
					end
					OP_ADDI: begin
						wr     = 1'b1;
						wr_reg = rt;
						wr_val = a + imm;
					end
					OP_BEQ: if (a == b) o.next_addr = seq + (imm << 2);
					OP_BNE: if (a != b) o.next_addr = seq + (imm << 2);
					OP_J:   o.next_addr = {seq[31:28], r.instr_word[25:0], 2'b00};
					OP_JAL: begin
						wr          = 1'b1;
						wr_reg      = REG_LINK;
						wr_val      = seq;
						o.next_addr = {seq[31:28], r.instr_word[25:0], 2'b00};
					end
					default: o.status = ST_BAD_OP;
				endcase
			end
		endcase
		// Register zero is hardwired, so a write to it is never reported.
		if (wr && wr_reg != 5'd0) begin
			gpr[wr_reg]    = wr_val;
			o.reg_write_en = 1'b1;
			o.dest_reg     = wr_reg;
			o.write_value  = wr_val;
		end
		return o;
	endfunction

	function automatic bit field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, sh,
			input logic [5:0] fn);
		return {OP_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
			input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
		return {op, tgt};
	endfunction

	// Appends one request to the tail of the pending queue.
	function automatic void enqueue_req(input isc_req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	// Unused fields of a request are filled with noise.
	function automatic isc_req_t exec_req(input logic [31:0] iw, input logic [31:0] pc);
		isc_req_t r;
		r.req_type     = REQ_EXEC;
		r.instr_word   = iw;
		r.instr_addr   = pc;
		r.target_index = 7'($urandom);
		r.load_value   = $urandom;
		return r;
	endfunction

	function automatic isc_req_t data_req(input logic [1:0] kind, input logic [6:0] idx,
			input logic [31:0] val);
		isc_req_t r;
		r              = exec_req($urandom, $urandom);
		r.req_type     = kind;
		r.target_index = idx;
		r.load_value   = val;
		return r;
	endfunction

	// Mostly a small pool of registers, so results feed straight into later beats.
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(99) < 70) return 5'($urandom_range(7));
		return 5'($urandom);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			4, 5, 6: return model_base + 32'($urandom_range(140)) * 4 - 32'd16;
			default: return $urandom;
		endcase
	endfunction

	function automatic isc_req_t random_req();
		logic [4:0]  rs, rt, rd;
		logic [15:0] off16;
		logic [31:0] pc;
		int          pick;
		rs    = pick_reg();
		rt    = pick_reg();
		rd    = pick_reg();
		pick  = $urandom_range(99);
		// Offsets that straddle both ends of the data window.
		off16 = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(600) - 64);
		pc    = ($urandom_range(1) == 0) ? $urandom : PC_START + 32'($urandom_range(1023)) * 4;
		if (pick < 12) begin
			return data_req(REQ_PRE_REG, ($urandom_range(3) != 0) ?
				7'($urandom_range(7)) : 7'($urandom), pick_value());
		end
		if (pick < 18) return data_req(REQ_PRE_DATA, 7'($urandom), pick_value());
		if (pick < 22) return data_req(REQ_RD_DATA, 7'($urandom), $urandom);
		case ($urandom_range(15))
			0:       return exec_req(enc_r(rs, rt, rd, 5'($urandom), FN_ADD), pc);
			1:       return exec_req(enc_r(rs, rt, rd, 5'($urandom), FN_SUB), pc);
			2:       return exec_req(enc_r(rs, rt, rd, 5'($urandom), FN_SLT), pc);
			3:       return exec_req(enc_r(rs, rt, rd, 5'($urandom), FN_SLL), pc);
			4:       return exec_req(enc_r(rs, rt, rd, 5'($urandom), FN_JR), pc);
			5, 6:    return exec_req(enc_i(OP_LW, rs, rt, off16), pc);
			7, 8:    return exec_req(enc_i(OP_SW, rs, rt, off16), pc);
			9:       return exec_req(enc_i(OP_ADDI, rs, rt, 16'($urandom)), pc);
			10:      return exec_req(enc_i(OP_BEQ, rs, rt, 16'($urandom)), pc);
			11:      return exec_req(enc_i(OP_BNE, rs, rt, 16'($urandom)), pc);
			12:      return exec_req(enc_j(OP_J, 26'($urandom)), pc);
			13:      return exec_req(enc_j(OP_JAL, 26'($urandom)), pc);
			14:      return exec_req(enc_r(rs, rt, rd, 5'($urandom), 6'($urandom)), pc);
			default: return exec_req($urandom, pc);
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
	endtask

	// The core must be idle here: every queued beat has been answered.
	task automatic write_base(input logic [31:0] base);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= base;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		model_base   = base;
		base_count++;
	endtask

	// Half the beats, a full drain with the sender silent, then the rest.
	task automatic run_random(input int count);
		@(negedge clk);
		repeat (count / 2) enqueue_req(random_req());
		wait_drained();
		@(negedge clk);
		repeat (count - count / 2) enqueue_req(random_req());
	endtask

	task automatic load_directed();
		logic [31:0] p;
		p = model_base;
		enqueue_req(data_req(REQ_RD_DATA, 7'd0, '0));
		enqueue_req(data_req(REQ_PRE_REG, 7'd0, 32'h1234_5678));
		enqueue_req(data_req(REQ_PRE_REG, 7'd100, 32'h1234_5678));
		enqueue_req(data_req(REQ_PRE_REG, 7'd1, 32'h7FFF_FFFF));
		enqueue_req(data_req(REQ_PRE_REG, 7'd2, 32'h8000_0000));
		enqueue_req(data_req(REQ_PRE_REG, 7'd3, p));
		enqueue_req(exec_req(enc_r(5'd1, 5'd1, 5'd4, 5'd0, FN_ADD), PC_START));
		enqueue_req(exec_req(enc_r(5'd2, 5'd1, 5'd5, 5'd0, FN_SUB), PC_START));
		enqueue_req(exec_req(enc_r(5'd2, 5'd1, 5'd6, 5'd0, FN_SLT), PC_START));
		enqueue_req(exec_req(enc_r(5'd1, 5'd2, 5'd7, 5'd0, FN_SLT), PC_START));
		enqueue_req(exec_req(enc_r(5'd0, 5'd1, 5'd8, 5'd31, FN_SLL), PC_START));
		enqueue_req(exec_req(enc_r(5'd1, 5'd1, 5'd0, 5'd0, FN_ADD), PC_START));
		enqueue_req(exec_req(enc_r(5'd1, 5'd2, 5'd9, 5'd0, FN_UNUSED), PC_START));
		enqueue_req(data_req(REQ_PRE_DATA, 7'd127, 32'hDEAD_BEEF));
		enqueue_req(exec_req(enc_i(OP_LW, 5'd3, 5'd9, 16'd508), PC_START));
		enqueue_req(exec_req(enc_i(OP_SW, 5'd3, 5'd1, 16'd0), PC_START));
		enqueue_req(data_req(REQ_RD_DATA, 7'd0, '0));
		// Just below and just above the data window.
		enqueue_req(exec_req(enc_i(OP_LW, 5'd3, 5'd10, 16'hFFFC), PC_START));
		enqueue_req(exec_req(enc_i(OP_SW, 5'd3, 5'd1, 16'd512), PC_START));
		enqueue_req(exec_req(enc_i(OP_ADDI, 5'd2, 5'd11, 16'hFFFF), 32'h0));
		enqueue_req(exec_req(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFF), PC_START));
		enqueue_req(exec_req(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF), PC_START));
		enqueue_req(exec_req(enc_i(OP_BNE, 5'd1, 5'd1, 16'h8000), PC_START));
		// The incremented fetch address wraps, so the jump region bits become zero.
		enqueue_req(exec_req(enc_j(OP_J, 26'h3FF_FFFF), 32'hFFFF_FFFC));
		enqueue_req(exec_req(enc_j(OP_JAL, 26'h0), 32'h0FFF_FFFC));
		enqueue_req(exec_req(enc_r(5'd2, 5'd0, 5'd0, 5'd0, FN_JR), PC_START));
		enqueue_req(exec_req(enc_i(OP_UNUSED, 5'd1, 5'd2, 16'h0), 32'hFFFF_FFFF));
		enqueue_req(data_req(REQ_RD_DATA, 7'd127, 32'hFFFF_FFFF));
	endtask

	// Sender: holds each beat until it is taken, and models it at that edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_rsps.insert(expected_rsps.size(), predict_beat(in_data));
				sent_by_type[in_data.req_type]++;
				void'(pending_reqs.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_reqs[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random backpressure and an in-order compare of each response.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response beat arrived with no request outstanding");
					fail_count++;
				end else begin
					rsp_want = expected_rsps.pop_front();
					rsp_bad  = field_differs("next_addr", rsp_want.next_addr, out_data.next_addr)
						| field_differs("reg_write_en", 32'(rsp_want.reg_write_en),
							32'(out_data.reg_write_en))
						| field_differs("dest_reg", 32'(rsp_want.dest_reg),
							32'(out_data.dest_reg))
						| field_differs("write_value", rsp_want.write_value,
							out_data.write_value)
						| field_differs("mem_write_en", 32'(rsp_want.mem_write_en),
							32'(out_data.mem_write_en))
						| field_differs("data_address", rsp_want.data_address,
							out_data.data_address)
						| field_differs("read_value", rsp_want.read_value, out_data.read_value)
						| field_differs("status", 32'(rsp_want.status), 32'(out_data.status));
					if (rsp_bad) fail_count++;
					status_seen[rsp_want.status]++;
					rsp_count++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		foreach (gpr[i]) gpr[i] = '0;
		foreach (dmem[i]) dmem[i] = '0;
		model_base = DATA_BASE_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Light sender gaps, heavy receiver backpressure.
		send_idle_pct = 6;
		recv_idle_pct = 77;
		@(negedge clk);
		load_directed();
		run_random(140);
		write_base(32'h0);
		run_random(140);

		// Heavy sender gaps, light backpressure, base at the top of the space.
		send_idle_pct = 77;
		recv_idle_pct = 6;
		write_base(32'hFFFF_FFFC);
		run_random(140);
		write_base(32'hFFFF_FF00);
		run_random(140);

		// Back to back in both directions.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_base({30'($urandom_range(32'h3FFF_FFFF)), 2'b00});
		run_random(140);
		write_base(DATA_BASE_RST);
		run_random(150);

		wait_drained();
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		$display("Sent %0d exec, %0d register preload, %0d data preload, %0d data read beats",
			sent_by_type[REQ_EXEC], sent_by_type[REQ_PRE_REG], sent_by_type[REQ_PRE_DATA],
			sent_by_type[REQ_RD_DATA]);
		$display("over %0d data base settings; %0d responses (%0d out of range, %0d bad opcode).",
			base_count, rsp_count, status_seen[ST_ADDR_ERR], status_seen[ST_BAD_OP]);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
